/* hw/rtl/pcicfg_pkg.sv */
// ----------------------------------------------------------------------------
// pcicfg_pkg
// types, codes and constants shared by the pci config space target
// ----------------------------------------------------------------------------
package pcicfg_pkg;

   // transaction codes
   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_INIT  = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_NODEV  = 2'd1;
   localparam logic [1:0] STAT_BADREG = 2'd2;

   // interrupt modes
   localparam logic [1:0] IRQ_INTX = 2'd0;
   localparam logic [1:0] IRQ_MSI  = 2'd1;
   localparam logic [1:0] IRQ_MSIX = 2'd2;

   // csr register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VENDOR   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAR_BASE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAR_LOG2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_IRQ_MODE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_IRQ_LINE = 3'd5;

   // csr reset values
   localparam logic [15:0] VENDOR_RESET   = 16'h1A4A;
   localparam logic [15:0] DEVICE_RESET   = 16'h2030;
   localparam logic [63:0] BAR_BASE_RESET = 64'h0;
   localparam logic [4:0]  BAR_LOG2_RESET = 5'd24;
   localparam logic [1:0]  IRQ_MODE_RESET = IRQ_INTX;
   localparam logic [7:0]  IRQ_LINE_RESET = 8'h00;

   // header offsets
   localparam logic [7:0] OFS_VENDOR  = 8'h00;
   localparam logic [7:0] OFS_CMD     = 8'h04;
   localparam logic [7:0] OFS_REV     = 8'h08;
   localparam logic [7:0] OFS_BAR0    = 8'h10;
   localparam logic [7:0] OFS_BAR1    = 8'h14;
   localparam logic [7:0] OFS_SUBVID  = 8'h2C;
   localparam logic [7:0] OFS_CAPPTR  = 8'h34;
   localparam logic [7:0] OFS_IRQLINE = 8'h3C;

   // header contents
   localparam logic [7:0]  REV_ID          = 8'h01;
   localparam logic [7:0]  CLASS_SUB       = 8'h80;
   localparam logic [7:0]  CLASS_BASE      = 8'h02;
   localparam logic [3:0]  BAR_TYPE_64     = 4'h4;
   localparam logic [31:0] BAR_FLAGS       = 32'h0000_0004;
   localparam logic [15:0] STATUS_CAP_LIST = 16'h0010;
   localparam logic [7:0]  MSIX_CAP_ID     = 8'h11;
   localparam logic [7:0]  MSI_CAP_ID      = 8'h05;
   localparam logic [7:0]  INT_PIN_A       = 8'h01;
   localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;

   // parameter defaults
   localparam int unsigned      SPACE_BYTES_DEF   = 256;
   localparam int unsigned      MSIX_CAP_AT_DEF   = 64;
   localparam int unsigned      MSI_CAP_AT_DEF    = 80;
   localparam logic [31:0]      MSIX_TABLE_AT_DEF = 32'h0001_0000;
   localparam logic [31:0]      MSIX_PBA_AT_DEF   = 32'h0001_1000;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_LO,
      ST_RD_HI,
      ST_WR_LO,
      ST_WR_HI,
      ST_INIT
   } state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  function_number;
      logic [7:0]  byte_offset;
      logic [2:0]  access_bytes;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  status;
   } rsp_type;

endpackage

/* hw/rtl/pcicfg_store.sv */
// ----------------------------------------------------------------------------
// pcicfg_store
// word wide config store with byte enables and a registered read port
// ----------------------------------------------------------------------------
module pcicfg_store import pcicfg_pkg::*; #(
   parameter int unsigned WORDS = SPACE_BYTES_DEF / 4,
   parameter int unsigned AW    = $clog2(SPACE_BYTES_DEF / 4)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [3:0]    wbe,
   input  logic [31:0]   wdata,
   input  logic [AW-1:0] raddr,
   output logic [31:0]   rdata
);

   logic [31:0] mem [WORDS];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         for (int b = 0; b < 4; b++) begin
            if (wbe[b]) begin
               mem[waddr][b*8 +: 8] <= wdata[b*8 +: 8];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/pci_config_space_target.sv */
// ----------------------------------------------------------------------------
// pci_config_space_target
// pci type-0 configuration space of one function with bar sizing
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its response
// shows on rsp_payload for one cycle under rsp_valid and cannot be held off.
// The space lives in a word store with one write port and a registered
// read port ((SPACE_BYTES+3)/4 words). A read or write inside one word passes
// through a first-word state, one that spans two words through a first-word and
// a second-word state, a rejected transaction is answered without leaving idle,
// and initialize walks every word. After reset a clearing pass over every word
// holds busy high; csr writes are taken at any time.
module pci_config_space_target import pcicfg_pkg::*; #(
   parameter int unsigned SPACE_BYTES   = SPACE_BYTES_DEF,
   parameter int unsigned MSIX_CAP_AT   = MSIX_CAP_AT_DEF,
   parameter int unsigned MSI_CAP_AT    = MSI_CAP_AT_DEF,
   parameter logic [31:0] MSIX_TABLE_AT = MSIX_TABLE_AT_DEF,
   parameter logic [31:0] MSIX_PBA_AT   = MSIX_PBA_AT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]            csr_data
);

   localparam int unsigned WORDS = (SPACE_BYTES + 3) / 4;
   localparam int unsigned AW    = $clog2(WORDS);

   // csr registers
   logic [15:0] vendor_ff;
   logic [15:0] device_ff;
   logic [63:0] bar_base_ff;
   logic [4:0]  bar_log2_ff;
   logic [1:0]  intr_sel_ff;
   logic [7:0]  irq_line_ff;

   // control and datapath
   state_type   state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] word0_ff, word1_ff;
   logic [63:0] wdata64_ff;
   logic [7:0]  be8_ff;
   logic [3:0]  bmask4_ff;
   logic [1:0]  shift_ff;
   logic [31:0] lo_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   // decode of the incoming transaction
   logic        accept;
   logic [12:0] end13;
   logic        width_ok;
   logic [3:0]  bmask4_in;
   logic [1:0]  dec_status;
   logic        dec_go;
   logic [31:0] dec_wdata;
   logic [31:0] bar_mask;
   logic [12:0] off13;

   // store ports
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [3:0]    mem_wbe;
   logic [31:0]   mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [31:0]   mem_rdata;

   logic [63:0] rd_pair;
   logic [31:0] rd_mask;
   logic [31:0] rd_val;

   function automatic logic [31:0] init_word(input logic [AW-1:0] widx);
      logic [31:0] w;
      logic [12:0] a0;
      logic [12:0] a;
      logic [12:0] d;
      logic [12:0] cap13;
      logic        has_cap;
      logic        is_msix;
      logic [7:0]  cap_id;
      logic [7:0]  bv;
      begin
         w       = '0;
         a0      = 13'({widx, 2'b00});
         is_msix = (intr_sel_ff == IRQ_MSIX);
         has_cap = is_msix || (intr_sel_ff == IRQ_MSI);
         cap13   = is_msix ? 13'(MSIX_CAP_AT) : 13'(MSI_CAP_AT);
         cap_id  = is_msix ? MSIX_CAP_ID : MSI_CAP_ID;
         if (a0 == 13'(OFS_VENDOR) || a0 == 13'(OFS_SUBVID)) begin
            w = {device_ff, vendor_ff};
         end
         if (a0 == 13'(OFS_CMD) && has_cap) begin
            w = {STATUS_CAP_LIST, 16'h0000};
         end
         if (a0 == 13'(OFS_REV)) begin
            w = {CLASS_BASE, CLASS_SUB, 8'h00, REV_ID};
         end
         if (a0 == 13'(OFS_BAR0)) begin
            w = {bar_base_ff[31:4], BAR_TYPE_64};
         end
         if (a0 == 13'(OFS_BAR1)) begin
            w = bar_base_ff[63:32];
         end
         if (a0 == 13'(OFS_CAPPTR) && has_cap) begin
            w = {24'h000000, 8'(cap13)};
         end
         if (a0 == 13'(OFS_IRQLINE)) begin
            w = {16'h0000, (has_cap ? 8'h00 : INT_PIN_A), irq_line_ff};
         end
         for (int b = 0; b < 4; b++) begin
            a  = a0 + 13'(b);
            d  = a - cap13;
            bv = 8'h00;
            if (has_cap && d == 13'd0) begin
               bv = cap_id;
            end else if (is_msix && d >= 13'd4 && d <= 13'd7) begin
               bv = 8'(MSIX_TABLE_AT >> {d[1:0], 3'b000});
            end else if (is_msix && d >= 13'd8 && d <= 13'd11) begin
               bv = 8'(MSIX_PBA_AT >> {d[1:0], 3'b000});
            end
            w[b*8 +: 8] = w[b*8 +: 8] | bv;
         end
         init_word = w;
      end
   endfunction

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vendor_ff   <= VENDOR_RESET;
         device_ff   <= DEVICE_RESET;
         bar_base_ff <= BAR_BASE_RESET;
         bar_log2_ff <= BAR_LOG2_RESET;
         intr_sel_ff <= IRQ_MODE_RESET;
         irq_line_ff <= IRQ_LINE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VENDOR:   vendor_ff   <= csr_data[15:0];
            CSR_DEVICE:   device_ff   <= csr_data[15:0];
            CSR_BAR_BASE: bar_base_ff <= csr_data;
            CSR_BAR_LOG2: bar_log2_ff <= csr_data[4:0];
            CSR_IRQ_MODE: intr_sel_ff <= csr_data[1:0];
            CSR_IRQ_LINE: irq_line_ff <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // transaction decode
   always_comb begin
      off13    = 13'(req_payload.byte_offset);
      end13    = off13 + 13'(req_payload.access_bytes);
      width_ok = (req_payload.access_bytes == 3'd1) || (req_payload.access_bytes == 3'd2)
              || (req_payload.access_bytes == 3'd4);
      case (req_payload.access_bytes)
         3'd1:    bmask4_in = 4'b0001;
         3'd2:    bmask4_in = 4'b0011;
         3'd4:    bmask4_in = 4'b1111;
         default: bmask4_in = 4'b0000;
      endcase
      if (req_payload.function_number != 8'h00) begin
         dec_status = STAT_NODEV;
      end else if (end13 > 13'(SPACE_BYTES) || !width_ok) begin
         dec_status = STAT_BADREG;
      end else begin
         dec_status = STAT_OK;
      end
      dec_go   = (dec_status == STAT_OK);
      bar_mask = ~((32'd1 << bar_log2_ff) - 32'd1) | BAR_FLAGS;
      if (req_payload.byte_offset == OFS_BAR0 && req_payload.access_bytes == 3'd4
          && req_payload.write_data == ALL_ONES) begin
         dec_wdata = bar_mask;
      end else begin
         dec_wdata = req_payload.write_data;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == AW'(WORDS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_payload.action)
                  ACT_INIT:  state_in = ST_INIT;
                  ACT_READ:  state_in = dec_go ? ST_RD_LO : ST_IDLE;
                  ACT_WRITE: state_in = dec_go ? ST_WR_LO : ST_IDLE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD_LO: state_in = (be8_ff[7:4] != 4'h0) ? ST_RD_HI : ST_IDLE;
         ST_RD_HI: state_in = ST_IDLE;
         ST_WR_LO: state_in = (be8_ff[7:4] != 4'h0) ? ST_WR_HI : ST_IDLE;
         ST_WR_HI: state_in = ST_IDLE;
         ST_INIT: begin
            if (cnt_ff == AW'(WORDS - 1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // read data alignment
   always_comb begin
      rd_pair = (state_ff == ST_RD_HI) ? {mem_rdata, lo_ff} : {32'h0, mem_rdata};
      rd_mask = {{8{bmask4_ff[3]}}, {8{bmask4_ff[2]}}, {8{bmask4_ff[1]}}, {8{bmask4_ff[0]}}};
      rd_val  = 32'(rd_pair >> {shift_ff, 3'b000}) & rd_mask;
   end

   // outputs of the sequencer
   always_comb begin
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff;
      mem_wbe      = 4'hF;
      mem_wdata    = 32'h0;
      mem_raddr    = AW'(off13 >> 2);
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '{read_data: 32'h0, status: STAT_OK};
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + AW'(1);
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               if (req_payload.action == ACT_READ || req_payload.action == ACT_WRITE) begin
                  rsp_valid_in = !dec_go;
                  rsp_in.status = dec_status;
                  if (req_payload.action == ACT_READ && !dec_go) begin
                     rsp_in.read_data = ALL_ONES;
                  end
               end else if (req_payload.action != ACT_INIT) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_RD_LO: begin
            mem_raddr    = word1_ff;
            rsp_valid_in = (be8_ff[7:4] == 4'h0);
            rsp_in.read_data = rd_val;
         end
         ST_RD_HI: begin
            mem_raddr    = word1_ff;
            rsp_valid_in = 1'b1;
            rsp_in.read_data = rd_val;
         end
         ST_WR_LO: begin
            mem_we       = 1'b1;
            mem_waddr    = word0_ff;
            mem_wbe      = be8_ff[3:0];
            mem_wdata    = wdata64_ff[31:0];
            rsp_valid_in = (be8_ff[7:4] == 4'h0);
         end
         ST_WR_HI: begin
            mem_we       = 1'b1;
            mem_waddr    = word1_ff;
            mem_wbe      = be8_ff[7:4];
            mem_wdata    = wdata64_ff[63:32];
            rsp_valid_in = 1'b1;
         end
         ST_INIT: begin
            mem_we       = 1'b1;
            mem_wdata    = init_word(cnt_ff);
            cnt_in       = cnt_ff + AW'(1);
            rsp_valid_in = (cnt_ff == AW'(WORDS - 1));
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (state_ff == ST_RD_LO) begin
         lo_ff <= mem_rdata;
      end
      if (accept) begin
         word0_ff   <= AW'(off13 >> 2);
         word1_ff   <= AW'((off13 >> 2) + 13'd1);
         shift_ff   <= req_payload.byte_offset[1:0];
         bmask4_ff  <= bmask4_in;
         be8_ff     <= 8'(bmask4_in) << req_payload.byte_offset[1:0];
         wdata64_ff <= 64'(dec_wdata) << {req_payload.byte_offset[1:0], 3'b000};
      end
   end

   pcicfg_store #(
      .WORDS (WORDS),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wbe   (mem_wbe),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // the second word of a read follows its first word
   a_rd_hi_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_HI) |-> ($past(state_ff) == ST_RD_LO))
      else $error("second read word without first");

   // the second word of a write only when the byte lanes spill over
   a_wr_hi_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR_HI) |-> ($past(state_ff) == ST_WR_LO && be8_ff[7:4] != 4'h0))
      else $error("second write word without spill");

   // the clearing pass ends without a response
   a_clear_silent: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_CLEAR && state_ff == ST_IDLE) |-> !rsp_valid_ff)
      else $error("response after clearing pass");

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// pci config space target: directed header accesses, bar sizing and error
// cases, then random read, write and initialize transactions under several
// csr settings and sender idle rates; every response is checked against a
// byte-level model of the configuration space
// ----------------------------------------------------------------------------
module testbench import pcicfg_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SPACE = SPACE_BYTES_DEF;
   localparam int unsigned PHASE_ITEMS = 170;
   localparam int unsigned DRAIN_CYCLES = 80;

   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam logic [1:0] IRQ_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_SPARE = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_SPARE = 3'd7;

   class space_scoreboard;
      logic [7:0]  space [SPACE];
      logic [15:0] vendor_id;
      logic [15:0] device_id;
      logic [63:0] bar_base;
      logic [4:0]  bar_log2;
      logic [1:0]  intr_sel;
      logic [7:0]  irq_line;
      rsp_type     pending_rsp [$];
      int          errors;

      function new();
         foreach (space[i]) space[i] = '0;
         vendor_id = VENDOR_RESET;
         device_id = DEVICE_RESET;
         bar_base = BAR_BASE_RESET;
         bar_log2 = BAR_LOG2_RESET;
         intr_sel = IRQ_MODE_RESET;
         irq_line = IRQ_LINE_RESET;
         errors = 0;
      endfunction

      function int unsigned outstanding();
         return pending_rsp.size();
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [63:0] d);
         case (idx)
            CSR_VENDOR:   vendor_id = d[15:0];
            CSR_DEVICE:   device_id = d[15:0];
            CSR_BAR_BASE: bar_base = d;
            CSR_BAR_LOG2: bar_log2 = d[4:0];
            CSR_IRQ_MODE: intr_sel = d[1:0];
            CSR_IRQ_LINE: irq_line = d[7:0];
            default: ;
         endcase
      endfunction

      function void put8(int unsigned at, logic [7:0] v);
         if (at < SPACE) space[at] = v;
      endfunction

      function void put16(int unsigned at, logic [15:0] v);
         put8(at, v[7:0]);
         put8(at + 1, v[15:8]);
      endfunction

      function void put32(int unsigned at, logic [31:0] v);
         put16(at, v[15:0]);
         put16(at + 2, v[31:16]);
      endfunction

      function void load_header();
         foreach (space[i]) space[i] = '0;
         put16(OFS_VENDOR, vendor_id);
         put16(OFS_VENDOR + 2, device_id);
         put8(OFS_REV, REV_ID);
         put8(OFS_REV + 2, CLASS_SUB);
         put8(OFS_REV + 3, CLASS_BASE);
         put32(OFS_BAR0, (bar_base[31:0] & 32'hFFFF_FFF0) | BAR_FLAGS);
         put32(OFS_BAR1, bar_base[63:32]);
         put16(OFS_SUBVID, vendor_id);
         put16(OFS_SUBVID + 2, device_id);
         put8(OFS_IRQLINE, irq_line);
         case (intr_sel)
            IRQ_MSIX: begin
               put16(OFS_CMD + 2, STATUS_CAP_LIST);
               put8(OFS_CAPPTR, 8'(MSIX_CAP_AT_DEF));
               put8(MSIX_CAP_AT_DEF, MSIX_CAP_ID);
               put32(MSIX_CAP_AT_DEF + 4, MSIX_TABLE_AT_DEF);
               put32(MSIX_CAP_AT_DEF + 8, MSIX_PBA_AT_DEF);
            end
            IRQ_MSI: begin
               put16(OFS_CMD + 2, STATUS_CAP_LIST);
               put8(OFS_CAPPTR, 8'(MSI_CAP_AT_DEF));
               put8(MSI_CAP_AT_DEF, MSI_CAP_ID);
            end
            default: begin
               put8(OFS_IRQLINE + 1, INT_PIN_A);
            end
         endcase
      endfunction

      function void take_request(req_type r);
         rsp_type     rsp;
         int unsigned width;
         int unsigned at;
         logic [31:0] mask;
         rsp.read_data = '0;
         rsp.status = STAT_OK;
         width = r.access_bytes;
         at = r.byte_offset;
         case (r.action)
            ACT_INIT: load_header();
            ACT_READ, ACT_WRITE: begin
               if (r.function_number != 8'd0) begin
                  rsp.status = STAT_NODEV;
               end else if (at + width > SPACE) begin
                  rsp.status = STAT_BADREG;
               end else if (!(width == 1 || width == 2 || width == 4)) begin
                  rsp.status = STAT_BADREG;
               end else if (r.action == ACT_READ) begin
                  for (int k = 0; k < width; k++) rsp.read_data[8*k +: 8] = space[at + k];
               end else if (at == OFS_BAR0 && width == 4 && r.write_data == ALL_ONES) begin
                  mask = ~((32'd1 << bar_log2) - 32'd1) | BAR_FLAGS;
                  put32(OFS_BAR0, mask);
               end else begin
                  for (int k = 0; k < width; k++) space[at + k] = r.write_data[8*k +: 8];
               end
               if (r.action == ACT_READ && rsp.status != STAT_OK) rsp.read_data = ALL_ONES;
            end
            default: ;
         endcase
         pending_rsp.push_back(rsp);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response, actual %h", $realtime, got);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.read_data !== want.read_data) begin
               $display("%0t: read_data mismatch, expected %h actual %h",
                        $realtime, want.read_data, got.read_data);
               errors++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d actual %0d",
                        $realtime, want.status, got.status);
               errors++;
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   rsp_type                rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]            csr_data = '0;

   space_scoreboard scoreboard = new();

   pci_config_space_target i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) scoreboard.write_register(csr_index, csr_data);
         if (start && !busy) scoreboard.take_request(req_payload);
         if (rsp_valid) scoreboard.check_response(rsp_payload);
      end
   end

   function automatic req_type make_req(logic [1:0] action, logic [7:0] fn, logic [7:0] ofs,
                                        logic [2:0] width, logic [31:0] data);
      req_type r;
      r.action = action;
      r.function_number = fn;
      r.byte_offset = ofs;
      r.access_bytes = width;
      r.write_data = data;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      r.action = pick < 46 ? ACT_READ : pick < 88 ? ACT_WRITE : pick < 96 ? ACT_INIT : ACT_NONE;
      r.function_number = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
      pick = $urandom_range(0, 99);
      r.byte_offset = pick < 55 ? 8'($urandom_range(0, 95)) :
                      pick < 90 ? 8'($urandom_range(0, 255)) : 8'($urandom_range(248, 255));
      pick = $urandom_range(0, 11);
      r.access_bytes = pick < 4 ? 3'd1 : pick < 8 ? 3'd2 : pick < 11 ? 3'd4 :
                       3'($urandom_range(0, 7));
      r.write_data = $urandom;
      if (r.action == ACT_WRITE && $urandom_range(0, 7) == 0) begin
         r.byte_offset = $urandom_range(0, 3) == 0 ? OFS_BAR1 : OFS_BAR0;
         r.access_bytes = 3'd4;
         r.write_data = ALL_ONES;
      end
      return r;
   endfunction

   function automatic int unsigned draw_gap(int unsigned pct);
      return ($urandom_range(0, 99) < pct) ? $urandom_range(1, 6) : 0;
   endfunction

   task automatic send_transaction(req_type r, int unsigned gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [63:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_setting(int unsigned n);
      case (n)
         0: begin
            write_csr(CSR_VENDOR, 64'h0);
            write_csr(CSR_DEVICE, 64'h0);
            write_csr(CSR_BAR_BASE, 64'h0);
            write_csr(CSR_BAR_LOG2, 64'h0);
            write_csr(CSR_IRQ_MODE, {62'h0, IRQ_MSIX});
            write_csr(CSR_IRQ_LINE, 64'h0);
         end
         1: begin
            write_csr(CSR_VENDOR, 64'hFFFF);
            write_csr(CSR_DEVICE, 64'hFFFF);
            write_csr(CSR_BAR_BASE, {64{1'b1}});
            write_csr(CSR_BAR_LOG2, 64'd31);
            write_csr(CSR_IRQ_MODE, {62'h0, IRQ_MSI});
            write_csr(CSR_IRQ_LINE, 64'hFF);
         end
         2: begin
            write_csr(CSR_VENDOR, {$urandom, $urandom});
            write_csr(CSR_DEVICE, {$urandom, $urandom});
            write_csr(CSR_BAR_BASE, {$urandom, $urandom});
            write_csr(CSR_BAR_LOG2, 64'd4);
            write_csr(CSR_IRQ_MODE, {62'h0, IRQ_UNUSED});
            write_csr(CSR_IRQ_LINE, {$urandom, $urandom});
         end
         default: begin
            write_csr(CSR_VENDOR, {$urandom, $urandom});
            write_csr(CSR_DEVICE, {$urandom, $urandom});
            write_csr(CSR_BAR_BASE, {$urandom, $urandom});
            write_csr(CSR_BAR_LOG2, {$urandom, 27'($urandom), 5'($urandom_range(0, 31))});
            write_csr(CSR_IRQ_MODE, {$urandom, $urandom});
            write_csr(CSR_IRQ_LINE, {$urandom, $urandom});
         end
      endcase
      write_csr($urandom_range(0, 1) ? CSR_LAST_SPARE : CSR_FIRST_SPARE, {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (scoreboard.outstanding() != 0 || busy);
   endtask

   initial begin
      int unsigned idle_pct;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed header, sizing and error transactions on the reset settings
      send_transaction(make_req(ACT_READ, 8'h00, 8'h00, 3'd4, 32'h0), 0);
      send_transaction(make_req(ACT_INIT, 8'hFF, 8'hFF, 3'd7, $urandom), 0);
      send_transaction(make_req(ACT_READ, 8'h00, OFS_VENDOR, 3'd4, 32'h0), draw_gap(11));
      send_transaction(make_req(ACT_READ, 8'h00, OFS_REV, 3'd4, 32'h0), 0);
      send_transaction(make_req(ACT_READ, 8'h00, OFS_BAR0, 3'd4, 32'h0), 0);
      send_transaction(make_req(ACT_WRITE, 8'h00, OFS_BAR0, 3'd4, ALL_ONES), draw_gap(11));
      send_transaction(make_req(ACT_READ, 8'h00, OFS_BAR0, 3'd4, 32'h0), 0);
      send_transaction(make_req(ACT_WRITE, 8'h00, OFS_BAR1, 3'd4, ALL_ONES), 0);
      send_transaction(make_req(ACT_READ, 8'h00, OFS_BAR1, 3'd4, 32'h0), 0);
      send_transaction(make_req(ACT_READ, 8'h00, OFS_IRQLINE, 3'd2, 32'h0), draw_gap(11));
      send_transaction(make_req(ACT_READ, 8'h01, 8'h00, 3'd4, 32'h0), 0);
      send_transaction(make_req(ACT_WRITE, 8'hFF, 8'h00, 3'd4, ALL_ONES), 0);
      send_transaction(make_req(ACT_READ, 8'h00, 8'hFD, 3'd4, 32'h0), 0);
      send_transaction(make_req(ACT_READ, 8'h00, 8'hFF, 3'd1, 32'h0), 0);
      send_transaction(make_req(ACT_WRITE, 8'h00, 8'hFC, 3'd4, ALL_ONES), draw_gap(11));
      send_transaction(make_req(ACT_READ, 8'h00, 8'hFC, 3'd4, 32'h0), 0);
      send_transaction(make_req(ACT_READ, 8'h00, 8'h00, 3'd0, 32'h0), 0);
      send_transaction(make_req(ACT_READ, 8'h00, 8'hFF, 3'd0, 32'h0), 0);
      send_transaction(make_req(ACT_READ, 8'h00, 8'h00, 3'd3, 32'h0), 0);
      send_transaction(make_req(ACT_WRITE, 8'h00, 8'h00, 3'd6, $urandom), 0);
      send_transaction(make_req(ACT_READ, 8'h00, 8'h00, 3'd5, 32'h0), 0);
      send_transaction(make_req(ACT_READ, 8'h00, 8'h00, 3'd7, 32'h0), 0);
      send_transaction(make_req(ACT_NONE, 8'($urandom), 8'($urandom), 3'($urandom), $urandom),
                       0);
      send_transaction(make_req(ACT_WRITE, 8'h00, 8'h0E, 3'd4, $urandom), draw_gap(11));
      send_transaction(make_req(ACT_READ, 8'h00, 8'h0D, 3'd4, 32'h0), 0);
      send_transaction(make_req(ACT_WRITE, 8'h00, 8'h03, 3'd2, $urandom), 0);
      send_transaction(make_req(ACT_READ, 8'h00, 8'h03, 3'd2, 32'h0), 0);

      for (int unsigned ph = 0; ph < 9; ph++) begin
         wait_idle();
         apply_setting(ph);
         idle_pct = ph < 3 ? 11 : ph < 6 ? 82 : 0;
         send_transaction(make_req(ACT_INIT, 8'h00, 8'h00, 3'd0, 32'h0), 0);
         for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
            send_transaction(random_request(), draw_gap(idle_pct));
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.errors == 0 && scoreboard.outstanding() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
